// ----- design/address_range_allocator_macros.svh -----
// ----------------------------------------------------------------------------
// Address range allocator assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef ADDRESS_RANGE_ALLOCATOR_MACROS_SVH
`define ADDRESS_RANGE_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define ARA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ARA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/ara_pkg.sv -----
// ----------------------------------------------------------------------------
// ara_pkg
// Types and constants of the address range allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ara_pkg;

   localparam int ADDR_W      = 32;
   localparam int EXT_W       = ADDR_W + 1;
   localparam int CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FREE_BASE_A = 3'd0,
      CSR_FREE_SIZE_A = 3'd1,
      CSR_FREE_BASE_B = 3'd2,
      CSR_FREE_SIZE_B = 3'd3,
      CSR_SEARCH_LIMIT = 3'd4
   } csr_index_type;

   typedef enum logic [0:0] {
      OP_AT_START = 1'b0,
      OP_ANYWHERE = 1'b1
   } operation_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LAUNCH,
      ST_REGION,
      ST_SCAN,
      ST_NEXT,
      ST_GRANT
   } state_type;

   typedef struct packed {
      logic done;
      logic granted;
      logic table_full;
   } result_ctl_type;

endpackage

// ----- design/ara_ram.sv -----
// ----------------------------------------------------------------------------
// ara_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ara_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/address_range_allocator.sv -----
// ----------------------------------------------------------------------------
// address_range_allocator
// Grants address ranges that fit a free region and overlap no used range.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration: csr_valid/csr_ready write channel, csr_index selects
//   free_base_a, free_size_a, free_base_b, free_size_b, search_limit.
//   csr_ready is always high; write only while busy is low.
//   Request: an item is taken when start is high and busy is low.
//   Operation 0 tries req_start_address; operation 1 tries 0, ALIGN_STEP,
//   2*ALIGN_STEP, ... below search_limit and takes the first fit.
//   Response: one item per request, shown for one cycle with rsp_valid.
//   The receiver cannot stall; the result must be taken when shown.
// Sequence:
//   A full table is refused at launch, before any search. Each candidate
//   is tested against both free regions, then scanned against the used
//   entries; a miss ends operation 0 and moves operation 1 on to the next
//   candidate, and operation 1 is refused once it reaches search_limit.
//   The used-table RAM is read one entry a cycle and checked by one shared
//   overlap compare.
// Reset: clears the configuration registers, the used count, the sequencer and the result strobe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module address_range_allocator #(
   parameter int USED_ENTRIES = 16,
   parameter int ALIGN_STEP   = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   // configuration
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ara_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ara_pkg::ADDR_W-1:0]         csr_data,
   // request
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_operation,
   input  logic [ara_pkg::ADDR_W-1:0]         req_start_address,
   input  logic [ara_pkg::ADDR_W-1:0]         req_range_length,
   // response
   output logic                               rsp_valid,
   output logic                               rsp_granted,
   output logic [ara_pkg::ADDR_W-1:0]         rsp_granted_address,
   output logic                               rsp_table_full
);

   import ara_pkg::*;

   localparam int IDX_W = (USED_ENTRIES > 1) ? $clog2(USED_ENTRIES) : 1;
   localparam int CNT_W = $clog2(USED_ENTRIES + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(USED_ENTRIES);
   localparam logic [EXT_W-1:0] STEP = EXT_W'(ALIGN_STEP);

   // configuration registers
   logic [ADDR_W-1:0] base_a_ff, size_a_ff, base_b_ff, size_b_ff, limit_ff;

   // sequencer and datapath
   state_type         state_ff, state_in;
   logic              op_ff, op_in;
   logic [ADDR_W-1:0] len_ff, len_in;
   logic [EXT_W-1:0]  cand_ff, cand_in;
   logic [EXT_W-1:0]  end_ff, end_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  scan_idx_ff, scan_idx_in;
   logic              cmp_valid_ff, cmp_valid_in;

   logic              rsp_valid_ff;
   logic              rsp_granted_ff;
   logic [ADDR_W-1:0] rsp_address_ff;
   logic              rsp_full_ff;

   result_ctl_type    res;

   logic              accept;
   logic              is_full;
   logic              cand_ok;
   logic              in_a, in_b;
   logic              issue, overlap, scan_fail, scan_pass;
   logic [EXT_W-1:0]  region_end_a, region_end_b;
   logic [EXT_W-1:0]  used_start, used_end;
   logic [2*ADDR_W-1:0] rd_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_a_ff <= '0;
         size_a_ff <= '0;
         base_b_ff <= '0;
         size_b_ff <= '0;
         limit_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FREE_BASE_A:  base_a_ff <= csr_data;
            CSR_FREE_SIZE_A:  size_a_ff <= csr_data;
            CSR_FREE_BASE_B:  base_b_ff <= csr_data;
            CSR_FREE_SIZE_B:  size_b_ff <= csr_data;
            CSR_SEARCH_LIMIT: limit_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   assign accept  = start && !busy;
   assign busy    = (state_ff != ST_IDLE);
   assign is_full = (count_ff == CNT_FULL);
   assign cand_ok = (op_ff == OP_AT_START) || (cand_ff < {1'b0, limit_ff});

   // region test
   assign region_end_a = {1'b0, base_a_ff} + {1'b0, size_a_ff};
   assign region_end_b = {1'b0, base_b_ff} + {1'b0, size_b_ff};
   assign in_a = (size_a_ff != '0) && (cand_ff >= {1'b0, base_a_ff})
                 && (end_ff <= region_end_a);
   assign in_b = (size_b_ff != '0) && (cand_ff >= {1'b0, base_b_ff})
                 && (end_ff <= region_end_b);

   // shared overlap compare, one used entry a cycle
   assign used_start = {1'b0, rd_data[2*ADDR_W-1:ADDR_W]};
   assign used_end   = used_start + {1'b0, rd_data[ADDR_W-1:0]};
   assign overlap    = (cand_ff < used_end) && (used_start < end_ff);
   assign issue      = (scan_idx_ff < count_ff);
   assign scan_fail  = cmp_valid_ff && overlap;
   assign scan_pass  = !issue && !scan_fail;

   ara_ram #(
      .WIDTH (2 * ADDR_W),
      .DEPTH (USED_ENTRIES)
   ) u_used_table (
      .clock   (clock),
      .wr_en   (state_ff == ST_GRANT),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data ({cand_ff[ADDR_W-1:0], len_ff}),
      .rd_en   ((state_ff == ST_SCAN) && issue),
      .rd_addr (scan_idx_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_LAUNCH;
         ST_LAUNCH: begin
            if (is_full || !cand_ok) state_in = ST_IDLE;
            else state_in = ST_REGION;
         end
         ST_REGION: state_in = (in_a || in_b) ? ST_SCAN : ST_NEXT;
         ST_SCAN: begin
            if (scan_fail) state_in = ST_NEXT;
            else if (scan_pass) state_in = ST_GRANT;
         end
         ST_NEXT:   state_in = (op_ff == OP_AT_START) ? ST_IDLE : ST_LAUNCH;
         ST_GRANT:  state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      op_in        = op_ff;
      len_in       = len_ff;
      cand_in      = cand_ff;
      end_in       = end_ff;
      count_in     = count_ff;
      scan_idx_in  = scan_idx_ff;
      cmp_valid_in = 1'b0;
      res          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in   = req_operation;
               len_in  = req_range_length;
               cand_in = (req_operation == OP_AT_START) ?
                         {1'b0, req_start_address} : '0;
            end
         end
         ST_LAUNCH: begin
            end_in      = cand_ff + {1'b0, len_ff};
            scan_idx_in = '0;
            if (is_full) begin
               res = '{done: 1'b1, granted: 1'b0, table_full: 1'b1};
            end else if (!cand_ok) begin
               res = '{done: 1'b1, granted: 1'b0, table_full: 1'b0};
            end
         end
         ST_REGION: ;
         ST_SCAN: begin
            if (issue) scan_idx_in = scan_idx_ff + 1'b1;
            cmp_valid_in = issue && !scan_fail;
         end
         ST_NEXT: begin
            if (op_ff == OP_AT_START) begin
               res = '{done: 1'b1, granted: 1'b0, table_full: 1'b0};
            end else begin
               cand_in = cand_ff + STEP;
            end
         end
         ST_GRANT: begin
            count_in = count_ff + 1'b1;
            res      = '{done: 1'b1, granted: 1'b1, table_full: 1'b0};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= res.done;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      len_ff      <= len_in;
      cand_ff     <= cand_in;
      end_ff      <= end_in;
      scan_idx_ff <= scan_idx_in;
      if (res.done) begin
         rsp_granted_ff <= res.granted;
         rsp_full_ff    <= res.table_full;
         rsp_address_ff <= res.granted ? cand_ff[ADDR_W-1:0] : '0;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_granted         = rsp_granted_ff;
   assign rsp_granted_address = rsp_address_ff;
   assign rsp_table_full      = rsp_full_ff;

endmodule

// ----- design/ara_checker.sv -----
// ----------------------------------------------------------------------------
// ara_checker
// Port-level checks of the address range allocator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "address_range_allocator_macros.svh"

module ara_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic                         rsp_valid,
   input logic                         rsp_granted,
   input logic [ara_pkg::ADDR_W-1:0]   rsp_granted_address,
   input logic                         rsp_table_full
);

   `ARA_ASSERT_NOW(a_full_not_granted, clock, reset, rsp_valid, !(rsp_granted && rsp_table_full), "item both granted and refused as full")
   `ARA_ASSERT_NOW(a_refused_zero_addr, clock, reset, rsp_valid && !rsp_granted, rsp_granted_address == '0, "refused item carries nonzero address")
   `ARA_ASSERT_NEXT(a_busy_after_start, clock, reset, start && !busy, busy, "accepted item did not raise busy")
   `ARA_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid, "result strobe held longer than one cycle")
   `ARA_ASSERT_NOW(a_idle_on_result, clock, reset, rsp_valid, !busy, "result shown while a request is in work")

endmodule

bind address_range_allocator ara_checker u_ara_checker (
   .clock               (clock),
   .reset               (reset),
   .start               (start),
   .busy                (busy),
   .rsp_valid           (rsp_valid),
   .rsp_granted         (rsp_granted),
   .rsp_granted_address (rsp_granted_address),
   .rsp_table_full      (rsp_table_full)
);
